>>> hdl/command_frame_receiver_crc8_defines.svh
// Assertion macros for the command frame receiver.
`ifndef COMMAND_FRAME_RECEIVER_CRC8_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_CRC8_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/cfr_pkg.sv
// Package: item types, register indexes and helpers for the frame receiver.
`timescale 1ns / 1ps
package cfr_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       converter_on;
    } cfr_in_t;

    typedef struct packed {
        logic        frame_valid;
        logic        boot_request;
        logic [31:0] chosen_target;
        logic        apply_now;
    } cfr_out_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER   = 3'd0,
        REG_TAIL     = 3'd1,
        REG_BOOT_CMD = 3'd2,
        REG_TGT_CMD  = 3'd3,
        REG_LOWER    = 3'd4,
        REG_UPPER    = 3'd5,
        REG_DEFAULT  = 3'd6
    } cfr_reg_idx_t;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // One CRC-8 byte update, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/cfr_range_check.sv
// Ordered IEEE single range check: lower < value < upper, NaN fails.
`timescale 1ns / 1ps
module cfr_range_check (
    input  logic [31:0] value,
    input  logic [31:0] lower,
    input  logic [31:0] upper,
    output logic        in_range
);
    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] okey(input logic [31:0] x);
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
        return !is_nan(a) && !is_nan(b) && (((a | b) & 32'h7FFF_FFFF) != 32'd0)
               && (okey(a) < okey(b));
    endfunction

    assign in_range = f_less(lower, value) && f_less(value, upper);
endmodule

>>> hdl/command_frame_receiver_crc8.sv
// Top level: fixed-length command frame receiver with CRC-8 check.
`timescale 1ns / 1ps
// Takes one received byte per item and groups them into 8-byte frames counted
// from reset, with no resync: header, command, four little-endian payload bytes
// forming an IEEE single, CRC-8 (poly 0x07, init 0) over bytes 1..5, tail.
// Items flow back to back unless the output stalls; only the last byte of a
// frame yields a result item, one register stage after acceptance. The result
// register is the only buffer, so input is taken when it is empty or being
// emptied. A valid target frame sets the stored target; chosen_target is the
// stored target if strictly between the bounds (float order, NaN fails), else
// default_target. Configuration must be written only when idle (not enforced).
module command_frame_receiver_crc8 #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  cfr_pkg::cfr_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output cfr_pkg::cfr_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfr_pkg::*;
    `include "command_frame_receiver_crc8_defines.svh"

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CRC  = POS_W'(FRAME_BYTES - 2);

    // configuration registers
    logic [7:0]  header_reg, tail_reg, boot_cmd_reg, tgt_cmd_reg;
    logic [31:0] lower_reg, upper_reg, default_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0; tail_reg <= '0; boot_cmd_reg <= '0; tgt_cmd_reg <= '0;
            lower_reg <= '0; upper_reg <= '0; default_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER:   header_reg   <= cfg_data[7:0];
                REG_TAIL:     tail_reg     <= cfg_data[7:0];
                REG_BOOT_CMD: boot_cmd_reg <= cfg_data[7:0];
                REG_TGT_CMD:  tgt_cmd_reg  <= cfg_data[7:0];
                REG_LOWER:    lower_reg    <= cfg_data;
                REG_UPPER:    upper_reg    <= cfg_data;
                REG_DEFAULT:  default_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [31:0]      payload_reg, payload_next;
    logic [7:0]       crc_reg, crc_next;
    logic             crc_ok_reg, crc_ok_next;
    logic [31:0]      target_reg, target_next;
    logic             out_valid_reg, out_valid_next;
    cfr_out_t         out_reg, out_next;

    logic accept, last, valid_frame, in_range;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign last     = (pos_reg == POS_LAST);
    assign valid_frame = hdr_ok_reg && crc_ok_reg && (in_data.rx_byte == tail_reg);

    cfr_range_check u_range (
        .value    (target_next),
        .lower    (lower_reg),
        .upper    (upper_reg),
        .in_range (in_range)
    );

    always_comb
    begin
        pos_next = pos_reg; hdr_ok_next = hdr_ok_reg; cmd_next = cmd_reg;
        payload_next = payload_reg; crc_next = crc_reg; crc_ok_next = crc_ok_reg;
        target_next = target_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        if (accept)
        begin
            pos_next = last ? '0 : pos_reg + 1'b1;
            if (pos_reg == '0)
            begin
                hdr_ok_next = (in_data.rx_byte == header_reg);
                crc_next    = '0;
            end
            else if (pos_reg == POS_CRC)
            begin
                crc_ok_next = (in_data.rx_byte == crc_reg);
            end
            else if (!last)
            begin
                if (pos_reg == POS_W'(1))
                    cmd_next = in_data.rx_byte;
                else
                    payload_next = {in_data.rx_byte, payload_reg[31:8]};
                crc_next = crc8_update(crc_reg, in_data.rx_byte);
            end
            else
            begin
                if (valid_frame && cmd_reg == tgt_cmd_reg)
                    target_next = payload_reg;
                out_valid_next         = 1'b1;
                out_next.frame_valid   = valid_frame;
                out_next.boot_request  = valid_frame && (cmd_reg == boot_cmd_reg);
                out_next.chosen_target = in_range ? target_next : default_reg;
                out_next.apply_now     = in_data.converter_on;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; hdr_ok_reg <= 1'b0; cmd_reg <= '0; payload_reg <= '0;
            crc_reg <= '0; crc_ok_reg <= 1'b0; target_reg <= '0; out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next; hdr_ok_reg <= hdr_ok_next; cmd_reg <= cmd_next;
            payload_reg <= payload_next; crc_reg <= crc_next; crc_ok_reg <= crc_ok_next;
            target_reg <= target_next; out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a result appears only after the last byte of a frame
    `CFR_ASSERT_NEXT(a_res_after_last, accept && !last && !(out_valid_reg && out_stall), !out_valid_reg)
    // boot request only on a valid frame
    `CFR_ASSERT_IMP(a_boot_valid, out_valid_reg && out_reg.boot_request, out_reg.frame_valid)
    // a pending result is never overwritten while stalled
    `CFR_ASSERT_NEXT(a_hold, out_valid_reg && out_stall, out_valid_reg && $stable(out_reg))
endmodule
